/* src/ptc_pkg.sv */
package ptc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_CALIB       = 3'd0;
    localparam logic [2:0] REG_PRESS_CALIB_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_CALIB_MID  = 3'd2;
    localparam logic [2:0] REG_PRESS_CALIB_LAST = 3'd3;

    localparam int DIV_CELLS = 32;

    // calibration words, already widened to 32 bits
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } calib_t;

    // per-beat sideband carried along the divider chain
    typedef struct packed {
        logic        vld;
        logic [15:0] tc;
        logic        tc_ok;
        logic        nz;
        logic        dbl;
    } side_t;

    // state of one divider cell
    typedef struct packed {
        side_t       side;
        logic [31:0] divisor;
        logic [32:0] rem;
        logic [31:0] dvd;
        logic [31:0] quo;
    } div_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] sv;
        sv = $signed(v);
        return 32'(sv >>> s);
    endfunction

endpackage

/* src/ptc_front.sv */
module ptc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            head_vld,
    input  logic [19:0]     raw_temp,
    input  logic [19:0]     raw_press,
    input  ptc_pkg::calib_t calib,
    output ptc_pkg::div_t   cell_out
);
    import ptc_pkg::*;

    logic [9:0]  vld_reg;
    logic [31:0] ta1_reg, d1_reg, m1_2_reg, dd2_reg, a3_reg, m3_3_reg, tf4_reg;
    logic [31:0] pa5_reg, q5_reg, sq6_reg, m5_6_reg, m2_6_reg;
    logic [31:0] b6_7_reg, m3b7_reg, m5_7_reg, m2_7_reg, b8_reg, a8_reg;
    logic [31:0] prod9_reg, pn9_reg, div10_reg, pm10_reg;
    logic [19:0] rp_reg [1:8];
    logic [15:0] tc_reg [5:10];
    logic        tcok_reg [5:10];
    div_t        out_reg;

    logic signed [35:0] tx;
    logic signed [35:0] tsh;
    logic [15:0]        tc_next;
    logic               tcok_next;
    logic [31:0]        pa_next;
    div_t               out_next;

    // temperature scaling, range check and saturation, and the pressure offset
    always_comb
    begin
        tx        = $signed({{4{tf4_reg[31]}}, tf4_reg}) * 36'sd5 + 36'sd128;
        tsh       = tx >>> 8;
        tcok_next = (tsh >= -36'sd4000) && (tsh <= 36'sd10000);
        if (tsh > 36'sd32767)
            tc_next = 16'h7fff;
        else if (tsh < -36'sd32768)
            tc_next = 16'h8000;
        else
            tc_next = tsh[15:0];
        pa_next = asr32(tf4_reg, 1) - 32'd64000;
    end

    // divider setup
    always_comb
    begin
        out_next.side.vld   = vld_reg[9];
        out_next.side.tc    = tc_reg[10];
        out_next.side.tc_ok = tcok_reg[10];
        out_next.side.nz    = (div10_reg != 32'd0);
        out_next.side.dbl   = pm10_reg[31];
        out_next.divisor    = div10_reg;
        out_next.rem        = '0;
        out_next.dvd        = pm10_reg[31] ? pm10_reg : {pm10_reg[30:0], 1'b0};
        out_next.quo        = '0;
    end

    // stage valid bits and divider input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:0], head_vld};
            out_reg <= out_next;
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta1_reg   <= {15'd0, raw_temp[19:3]} - {calib.t1[30:0], 1'b0};
            d1_reg    <= {16'd0, raw_temp[19:4]} - calib.t1;
            rp_reg[1] <= raw_press;
            for (int i = 2; i <= 8; i++)
            begin
                rp_reg[i] <= rp_reg[i-1];
            end

            m1_2_reg <= ta1_reg * calib.t2;
            dd2_reg  <= d1_reg * d1_reg;

            a3_reg   <= asr32(m1_2_reg, 11);
            m3_3_reg <= asr32(dd2_reg, 12) * calib.t3;

            tf4_reg <= a3_reg + asr32(m3_3_reg, 14);

            tc_reg[5]   <= tc_next;
            tcok_reg[5] <= tcok_next;
            pa5_reg     <= pa_next;
            q5_reg      <= asr32(pa_next, 2);
            for (int i = 6; i <= 10; i++)
            begin
                tc_reg[i]   <= tc_reg[i-1];
                tcok_reg[i] <= tcok_reg[i-1];
            end

            sq6_reg  <= q5_reg * q5_reg;
            m5_6_reg <= pa5_reg * calib.p5;
            m2_6_reg <= calib.p2 * pa5_reg;

            b6_7_reg <= asr32(sq6_reg, 11) * calib.p6;
            m3b7_reg <= calib.p3 * asr32(sq6_reg, 13);
            m5_7_reg <= m5_6_reg;
            m2_7_reg <= m2_6_reg;

            b8_reg <= asr32(b6_7_reg + {m5_7_reg[30:0], 1'b0}, 2) + {calib.p4[15:0], 16'd0};
            a8_reg <= asr32(asr32(m3b7_reg, 3) + asr32(m2_7_reg, 1), 18);

            prod9_reg <= (32'd32768 + a8_reg) * calib.p1;
            pn9_reg   <= (32'd1048576 - {12'd0, rp_reg[8]}) - asr32(b8_reg, 12);

            div10_reg <= asr32(prod9_reg, 15);
            pm10_reg  <= pn9_reg * 32'd3125;
        end
    end

    assign cell_out = out_reg;

endmodule

/* src/ptc_div_cell.sv */
module ptc_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ptc_pkg::div_t cell_in,
    output ptc_pkg::div_t cell_out
);
    import ptc_pkg::*;

    div_t        cell_reg;
    div_t        cell_next;
    logic [32:0] rem_sh;
    logic        ge;

    // one restoring quotient bit
    always_comb
    begin
        rem_sh    = {cell_in.rem[31:0], cell_in.dvd[31]};
        ge        = rem_sh >= {1'b0, cell_in.divisor};
        cell_next = cell_in;
        cell_next.rem = ge ? rem_sh - {1'b0, cell_in.divisor} : rem_sh;
        cell_next.dvd = {cell_in.dvd[30:0], 1'b0};
        cell_next.quo = {cell_in.quo[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

/* src/ptc_back.sv */
module ptc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ptc_pkg::div_t      cell_in,
    input  ptc_pkg::calib_t    calib,
    output logic               out_valid,
    output logic signed [15:0] temp_centi,
    output logic [31:0]        press_pa,
    output logic               valid_res,
    output logic               plausible
);
    import ptc_pkg::*;

    side_t       sa_reg, sb_reg;
    logic [31:0] pa_reg, sqa_reg, mba_reg, pb_reg, ab_reg, mbb_reg;
    logic        vld_reg;
    logic [15:0] tc_reg;
    logic [31:0] press_reg;
    logic        nz_reg, plaus_reg;

    logic [31:0] pa_next, q3, pf;
    logic        plaus_next;

    // undo the halved dividend, then finish pressure
    always_comb
    begin
        pa_next    = cell_in.side.dbl ? {cell_in.quo[30:0], 1'b0} : cell_in.quo;
        q3         = pa_next >> 3;
        pf         = pb_reg + asr32(asr32(ab_reg, 12) + mbb_reg + calib.p7, 4);
        plaus_next = sb_reg.nz && sb_reg.tc_ok && (pf >= 32'd30000) && (pf <= 32'd130099);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg  <= '0;
            sb_reg  <= '0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_reg  <= cell_in.side;
            sb_reg  <= sa_reg;
            vld_reg <= sb_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_next;
            sqa_reg <= q3 * q3;
            mba_reg <= (pa_next >> 2) * calib.p8;

            pb_reg  <= pa_reg;
            ab_reg  <= calib.p9 * (sqa_reg >> 13);
            mbb_reg <= asr32(mba_reg, 13);

            tc_reg    <= sb_reg.tc;
            press_reg <= sb_reg.nz ? pf : 32'd0;
            nz_reg    <= sb_reg.nz;
            plaus_reg <= plaus_next;
        end
    end

    assign out_valid  = vld_reg;
    assign temp_centi = $signed(tc_reg);
    assign press_pa   = press_reg;
    assign valid_res  = nz_reg;
    assign plausible  = plaus_reg;

endmodule

/* src/pressure_temp_compensation_core.sv */
// throughput: one beat per cycle while no result waits; the quotient comes from a
// 32-cell divider chain, one quotient bit per cell, behind eleven setup stages and
// three finishing stages
// the whole pipe holds while a result waits; a skid stage takes one more input beat
// reset: asynchronous active low, clears valid bits and calibration registers to zero
module pressure_temp_compensation_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_temp,
    input  logic [19:0]        raw_press,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temp_centi,
    output logic [31:0]        press_pa,
    output logic               valid_res,
    output logic               plausible
);
    import ptc_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg, press_mid_reg;
    logic [15:0] press_last_reg;
    logic        skid_full_reg, skid_full_next;
    logic [19:0] skid_temp_reg, skid_press_reg;
    logic        adv, take, head_vld;
    logic [19:0] head_temp, head_press;
    calib_t      calib;
    div_t        chain [0:DIV_CELLS];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_CALIB:       temp_calib_reg <= cfg_data[47:0];
                REG_PRESS_CALIB_LOW:  press_low_reg  <= cfg_data;
                REG_PRESS_CALIB_MID:  press_mid_reg  <= cfg_data;
                REG_PRESS_CALIB_LAST: press_last_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // unpack calibration words
    always_comb
    begin
        calib.t1 = {16'd0, temp_calib_reg[15:0]};
        calib.t2 = {{16{temp_calib_reg[31]}}, temp_calib_reg[31:16]};
        calib.t3 = {{16{temp_calib_reg[47]}}, temp_calib_reg[47:32]};
        calib.p1 = {16'd0, press_low_reg[15:0]};
        calib.p2 = {{16{press_low_reg[31]}}, press_low_reg[31:16]};
        calib.p3 = {{16{press_low_reg[47]}}, press_low_reg[47:32]};
        calib.p4 = {{16{press_low_reg[63]}}, press_low_reg[63:48]};
        calib.p5 = {{16{press_mid_reg[15]}}, press_mid_reg[15:0]};
        calib.p6 = {{16{press_mid_reg[31]}}, press_mid_reg[31:16]};
        calib.p7 = {{16{press_mid_reg[47]}}, press_mid_reg[47:32]};
        calib.p8 = {{16{press_mid_reg[63]}}, press_mid_reg[63:48]};
        calib.p9 = {{16{press_last_reg[15]}}, press_last_reg};
    end

    // input skid and pipe advance
    always_comb
    begin
        adv            = !(out_valid && out_stall);
        take           = in_valid && !skid_full_reg;
        head_vld       = skid_full_reg || take;
        head_temp      = skid_full_reg ? skid_temp_reg : raw_temp;
        head_press     = skid_full_reg ? skid_press_reg : raw_press;
        skid_full_next = adv ? 1'b0 : (skid_full_reg || take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else
            skid_full_reg <= skid_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (!adv && take)
        begin
            skid_temp_reg  <= raw_temp;
            skid_press_reg <= raw_press;
        end
    end

    assign in_stall = skid_full_reg;

    ptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .head_vld  (head_vld),
        .raw_temp  (head_temp),
        .raw_press (head_press),
        .calib     (calib),
        .cell_out  (chain[0])
    );

    // divider chain
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        ptc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .cell_in    (chain[DIV_CELLS]),
        .calib      (calib),
        .out_valid  (out_valid),
        .temp_centi (temp_centi),
        .press_pa   (press_pa),
        .valid_res  (valid_res),
        .plausible  (plausible)
    );

endmodule

/* src/ptc_checker.sv */
module ptc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [31:0]        press_pa,
    input logic               valid_res,
    input logic               plausible
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped under stall");

    // zero divisor gives zero pressure and no plausibility
    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> press_pa == 32'd0 && !plausible)
        else $error("invalid result carries pressure");

    // plausibility implies a good division
    a_plaus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && plausible |-> valid_res)
        else $error("plausible without valid result");

    // input only stalls after the output was held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind pressure_temp_compensation_core ptc_checker u_chk (.*);
